[design/dst_pkg.sv]
// ---------------------------------------------------------------------------
// Diagnostic session table package
// Payload types, slot record layout and the action, event and state codes.
// ---------------------------------------------------------------------------
package dst_pkg;

    // Action codes of one input item.
    localparam logic [2:0] ACT_CREATE  = 3'd0;
    localparam logic [2:0] ACT_DESTROY = 3'd1;
    localparam logic [2:0] ACT_EVENT   = 3'd2;
    localparam logic [2:0] ACT_TOUCH   = 3'd3;
    localparam logic [2:0] ACT_CHECK   = 3'd4;

    // Event codes.
    localparam logic [2:0] EV_TIMEOUT  = 3'd0;
    localparam logic [2:0] EV_REQUEST  = 3'd1;
    localparam logic [2:0] EV_SECURITY = 3'd2;
    localparam logic [2:0] EV_ERROR    = 3'd3;
    localparam logic [2:0] EV_RESPONSE = 3'd4;
    localparam logic [2:0] EV_RESET    = 3'd5;

    // Session states.
    localparam logic [2:0] ST_DEFAULT  = 3'd0;
    localparam logic [2:0] ST_PROG     = 3'd1;
    localparam logic [2:0] ST_EXTENDED = 3'd2;
    localparam logic [2:0] ST_SAFETY   = 3'd3;
    localparam logic [2:0] ST_SUPPLIER = 3'd4;
    localparam logic [2:0] ST_EOL      = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_ERR   = 3'd0;
    localparam logic [2:0] CFG_REQ_SEC   = 3'd1;
    localparam logic [2:0] CFG_NESTED    = 3'd2;
    localparam logic [2:0] CFG_AUTO_CLR  = 3'd3;
    localparam logic [2:0] CFG_S3_TMO    = 3'd4;

    // Service bytes and the sweep interval.
    localparam logic [7:0]  SVC_SESSION_CTRL = 8'h10;
    localparam logic [7:0]  SVC_SEC_ACCESS   = 8'h27;
    localparam logic [31:0] CHECK_INTERVAL   = 32'd100;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] target_id;
        logic [2:0]  event_code;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [31:0] new_id;
        logic [2:0]  session_state;
        logic [4:0]  active_count;
    } t_out;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  state;
        logic [7:0]  security;
        logic [7:0]  errors;
        logic [31:0] last;
    } t_slot;

    typedef struct packed {
        logic [7:0]  max_err;
        logic        req_sec;
        logic        nested;
        logic        auto_clr;
        logic [31:0] s3_tmo;
    } t_cfg;

    typedef struct packed {
        t_slot slot;
        logic  good;
    } t_evt_res;

endpackage

[design/dst_evt.sv]
// ---------------------------------------------------------------------------
// Session event transition
// Applies one event to a slot record through the fixed transition table.
// ---------------------------------------------------------------------------
module dst_evt (
    input  dst_pkg::t_slot    i_slot,
    input  logic [2:0]        i_ev,
    input  logic [7:0]        i_b0,
    input  logic [7:0]        i_b1,
    input  logic [31:0]       i_now,
    input  dst_pkg::t_cfg     i_cfg,
    output dst_pkg::t_evt_res o_res
);

    logic [7:0] w_err_inc;

    // Saturating error count.
    assign w_err_inc = (i_slot.errors == 8'hFF) ? i_slot.errors : i_slot.errors + 8'd1;

    // Transition table; fields change even on some failed events.
    always_comb begin
        o_res.slot = i_slot;
        o_res.good = 1'b0;
        priority if (i_slot.state == dst_pkg::ST_DEFAULT && i_ev == dst_pkg::EV_TIMEOUT) begin
            o_res.slot.security = 8'd0;
            o_res.slot.errors   = 8'd0;
            o_res.good          = 1'b1;
        end else if (i_slot.state == dst_pkg::ST_DEFAULT && i_ev == dst_pkg::EV_REQUEST) begin
            if (i_b0 == dst_pkg::SVC_SESSION_CTRL) begin
                o_res.slot.last  = i_now;
                o_res.slot.state = dst_pkg::ST_EXTENDED;
                o_res.good       = 1'b1;
            end
        end else if (i_slot.state == dst_pkg::ST_PROG && i_ev == dst_pkg::EV_SECURITY) begin
            if (i_slot.errors >= i_cfg.max_err) begin
                o_res.good = 1'b0;
            end else if (i_b0 == dst_pkg::SVC_SEC_ACCESS) begin
                o_res.slot.security = i_b1;
                o_res.slot.errors   = 8'd0;
                o_res.good          = 1'b1;
            end else begin
                o_res.slot.errors = w_err_inc;
            end
        end else if (i_slot.state == dst_pkg::ST_EXTENDED && i_ev == dst_pkg::EV_REQUEST) begin
            if (!(i_cfg.req_sec && i_slot.security == 8'd0)) begin
                o_res.slot.last = i_now;
                o_res.good      = 1'b1;
            end
        end else if (i_slot.state == dst_pkg::ST_SAFETY && i_ev == dst_pkg::EV_ERROR) begin
            o_res.slot.errors = w_err_inc;
            if (w_err_inc >= i_cfg.max_err) begin
                o_res.slot.state = dst_pkg::ST_DEFAULT;
                o_res.good       = 1'b1;
            end
        end else if (i_slot.state == dst_pkg::ST_SUPPLIER && i_ev == dst_pkg::EV_RESPONSE) begin
            o_res.slot.last = i_now;
            o_res.good      = 1'b1;
        end else if (i_slot.state == dst_pkg::ST_EOL && i_ev == dst_pkg::EV_RESET) begin
            o_res.slot.security = 8'd0;
            o_res.slot.errors   = 8'd0;
            o_res.slot.state    = dst_pkg::ST_DEFAULT;
            o_res.good          = 1'b1;
        end else begin
            o_res.good = 1'b0;
        end
    end

endmodule

[design/diag_session_table_fsm.sv]
// Create and rejected items pass from accept straight to the done state.
// Lookup items scan the slot memory one entry per cycle and stop at a match.
// The timeout sweep reads every slot, only once CHECK_INTERVAL has elapsed.
// One item at a time; the next is taken once the result is queued for output.
// Reset clears all control state and slot valid bits; an invalid slot is free.
// ---------------------------------------------------------------------------
// Diagnostic session table
// Session records live in a one-port-write, one-port-read slot memory; a
// sequencer walks it for id lookup and the S3 timeout sweep.
// ---------------------------------------------------------------------------
module diag_session_table_fsm #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  dst_pkg::t_in    i_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output dst_pkg::t_out   o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic        ok;
        logic [31:0] new_id;
        logic [2:0]  sst;
    } t_pend;

    t_state            r_state, n_state;
    dst_pkg::t_in      r_item, n_item;
    dst_pkg::t_cfg     r_cfg;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [CW-1:0]     r_count, n_count;
    logic [31:0]       r_next, n_next;
    logic [31:0]       r_last_chk, n_last_chk;
    logic [CW-1:0]     r_ra, n_ra;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_pa, n_pa;
    t_pend             r_pend, n_pend;
    logic              r_ov, n_ov;
    dst_pkg::t_out     r_res, n_res;

    // Slot memory and its registered read port.
    dst_pkg::t_slot    r_mem [SLOTS];
    dst_pkg::t_slot    r_rd;
    logic              r_rdv;
    logic [AW-1:0]     w_rd_addr;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    dst_pkg::t_slot    w_wd;

    // Lowest free slot.
    logic              w_free_found;
    logic [AW-1:0]     w_free_idx;

    dst_pkg::t_evt_res w_evt;
    logic [2:0]        w_evt_code;
    logic              w_sweep;
    logic              w_last;
    logic [31:0]       w_idle_time;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_res_valid  = r_ov;
    assign o_res        = r_res;

    assign w_sweep    = (r_item.action == dst_pkg::ACT_CHECK);
    assign w_evt_code = w_sweep ? dst_pkg::EV_TIMEOUT : r_item.event_code;
    assign w_rd_addr  = r_ra[AW-1:0];
    assign w_last     = (r_pa == AW'(SLOTS - 1));
    assign w_idle_time = r_item.now_ms - r_rd.last;

    dst_evt u_evt (
        .i_slot (r_rd),
        .i_ev   (w_evt_code),
        .i_b0   (r_item.first_byte),
        .i_b1   (r_item.second_byte),
        .i_now  (r_item.now_ms),
        .i_cfg  (r_cfg),
        .o_res  (w_evt)
    );

    // Priority encoder for the first unused slot.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free_found = 1'b1;
                w_free_idx   = AW'(k);
            end
        end
    end

    // Sequencer and read-modify-write control.
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_valid    = r_valid;
        n_count    = r_count;
        n_next     = r_next;
        n_last_chk = r_last_chk;
        n_ra       = r_ra;
        n_pv       = 1'b0;
        n_pa       = r_pa;
        n_pend     = r_pend;
        n_ov       = r_ov && !i_res_ready;
        n_res      = r_res;
        w_we       = 1'b0;
        w_wa       = r_pa;
        w_wd       = w_evt.slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item = i_item;
                    n_pend = '0;
                    n_ra   = '0;
                    n_state = S_DONE;
                    unique case (i_item.action)
                        dst_pkg::ACT_CREATE: begin
                            if (w_free_found) begin
                                w_we    = 1'b1;
                                w_wa    = w_free_idx;
                                w_wd    = '0;
                                w_wd.id = r_next;
                                w_wd.last = i_item.now_ms;
                                n_valid[w_free_idx] = 1'b1;
                                n_count = r_count + CW'(1);
                                n_next  = (r_next == 32'hFFFF_FFFF) ? 32'd1 : r_next + 32'd1;
                                n_pend.ok     = 1'b1;
                                n_pend.new_id = r_next;
                            end
                        end
                        dst_pkg::ACT_DESTROY, dst_pkg::ACT_TOUCH: begin
                            if (i_item.target_id != 32'd0) begin
                                n_state = S_SCAN;
                            end
                        end
                        dst_pkg::ACT_EVENT: begin
                            if (i_item.target_id != 32'd0 &&
                                i_item.event_code <= dst_pkg::EV_RESET) begin
                                n_state = S_SCAN;
                            end
                        end
                        dst_pkg::ACT_CHECK: begin
                            if (i_item.now_ms - r_last_chk >= dst_pkg::CHECK_INTERVAL) begin
                                n_last_chk = i_item.now_ms;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue the next read while the previous entry is examined.
                if (r_ra < CW'(SLOTS)) begin
                    n_ra = r_ra + CW'(1);
                    n_pv = 1'b1;
                    n_pa = r_ra[AW-1:0];
                end
                if (r_pv) begin
                    if (w_sweep) begin
                        if (r_rdv && w_idle_time > r_cfg.s3_tmo) begin
                            w_we = 1'b1;
                            if (r_cfg.auto_clr) begin
                                n_valid[r_pa] = 1'b0;
                                n_count = r_count - CW'(1);
                            end
                        end
                        if (w_last) begin
                            n_pend.ok = 1'b1;
                            n_state   = S_DONE;
                        end
                    end else if (r_rdv && r_rd.id == r_item.target_id) begin
                        n_state = S_DONE;
                        n_pend.ok = 1'b1;
                        unique case (r_item.action)
                            dst_pkg::ACT_DESTROY: begin
                                n_valid[r_pa] = 1'b0;
                                n_count = r_count - CW'(1);
                            end
                            dst_pkg::ACT_TOUCH: begin
                                w_we      = 1'b1;
                                w_wd      = r_rd;
                                w_wd.last = r_item.now_ms;
                            end
                            default: begin
                                w_we       = 1'b1;
                                n_pend.ok  = w_evt.good;
                                n_pend.sst = w_evt.slot.state;
                            end
                        endcase
                    end else if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ov || i_res_ready) begin
                    n_ov  = 1'b1;
                    n_res.ok            = r_pend.ok;
                    n_res.new_id        = r_pend.new_id;
                    n_res.session_state = r_pend.sst;
                    n_res.active_count  = 5'(r_count);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pa   <= n_pa;
        r_pend <= n_pend;
        r_res  <= n_res;
        r_ra   <= n_ra;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_count    <= '0;
            r_next     <= 32'd1;
            r_last_chk <= 32'd0;
            r_pv       <= 1'b0;
            r_rdv      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_next     <= n_next;
            r_last_chk <= n_last_chk;
            r_pv       <= n_pv;
            r_rdv      <= r_valid[w_rd_addr];
            r_ov       <= n_ov;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_err  <= 8'd3;
            r_cfg.req_sec  <= 1'b0;
            r_cfg.nested   <= 1'b1;
            r_cfg.auto_clr <= 1'b0;
            r_cfg.s3_tmo   <= 32'd5000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dst_pkg::CFG_MAX_ERR:  r_cfg.max_err  <= i_cfg_data[7:0];
                dst_pkg::CFG_REQ_SEC:  r_cfg.req_sec  <= i_cfg_data[0];
                dst_pkg::CFG_NESTED:   r_cfg.nested   <= i_cfg_data[0];
                dst_pkg::CFG_AUTO_CLR: r_cfg.auto_clr <= i_cfg_data[0];
                dst_pkg::CFG_S3_TMO:   r_cfg.s3_tmo   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The session count tracks the used slots.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("session count differs from used slots");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("session count above table size");

    // Issued ids never become zero.
    a_next_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != 32'd0)
        else $error("next session id is zero");

endmodule
